// ----- hw/rtl/hgc_pkg.sv -----
// shared types, constants and elaboration-time tables for the haversine geofence check
// no dependencies; used by hgc_cordic_cell, hgc_sqrt_cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package hgc_pkg;

  localparam int HGC_CORDIC_STAGES = 24;
  localparam int HGC_SQRT_STEPS    = 31;
  localparam int HGC_CW            = 34;
  localparam int HGC_SW            = 62;

  localparam logic [63:0] HGC_PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] HGC_DEG2RAD  = HGC_PI_Q60 / 64'd1800000000;
  localparam logic signed [HGC_CW-1:0] HGC_KINV     = 34'sh26DD3B6A;
  localparam logic signed [33:0]       HGC_HALF_DEG = 34'sd1800000000;
  localparam logic signed [33:0]       HGC_FULL_DEG = 34'sd3600000000;
  localparam logic [31:0] HGC_QUARTER_DEG = 32'd900000000;
  localparam logic [31:0] HGC_HALF_DEG_U  = 32'd1800000000;
  localparam logic [23:0] HGC_TWO_R       = 24'd12742000;
  localparam logic [25:0] HGC_HALF_CIRC   = 26'd20015087;
  localparam logic [60:0] HGC_ONE_Q60     = 61'h1000000000000000;

  typedef enum logic [1:0] {
    HGC_REG_CLAT   = 2'd0,
    HGC_REG_CLON   = 2'd1,
    HGC_REG_RADIUS = 2'd2
  } hgc_reg_t;

  typedef struct packed {
    logic signed [30:0] pos_lat;
    logic signed [31:0] pos_lon;
  } hgc_in_t;

  typedef struct packed {
    logic        inside_res;
    logic [24:0] distance_m;
  } hgc_out_t;

  typedef struct packed {
    logic signed [HGC_CW-1:0] x;
    logic signed [HGC_CW-1:0] y;
    logic signed [HGC_CW-1:0] z;
  } hgc_cordic_t;

  typedef struct packed {
    logic [HGC_SW-1:0] rem;
    logic [HGC_SW-1:0] res;
  } hgc_sqrt_t;

  // one term of the arctan series, 2^(62-e) / (2k+1)
  function automatic logic [63:0] hgc_atan_term(int k, int e);
    logic [63:0] p;
    p = 64'd1 << (62 - e);
    case (k)
      0:  hgc_atan_term = p;
      1:  hgc_atan_term = p / 64'd3;
      2:  hgc_atan_term = p / 64'd5;
      3:  hgc_atan_term = p / 64'd7;
      4:  hgc_atan_term = p / 64'd9;
      5:  hgc_atan_term = p / 64'd11;
      6:  hgc_atan_term = p / 64'd13;
      7:  hgc_atan_term = p / 64'd15;
      8:  hgc_atan_term = p / 64'd17;
      9:  hgc_atan_term = p / 64'd19;
      10: hgc_atan_term = p / 64'd21;
      11: hgc_atan_term = p / 64'd23;
      12: hgc_atan_term = p / 64'd25;
      13: hgc_atan_term = p / 64'd27;
      14: hgc_atan_term = p / 64'd29;
      15: hgc_atan_term = p / 64'd31;
      16: hgc_atan_term = p / 64'd33;
      17: hgc_atan_term = p / 64'd35;
      18: hgc_atan_term = p / 64'd37;
      19: hgc_atan_term = p / 64'd39;
      20: hgc_atan_term = p / 64'd41;
      21: hgc_atan_term = p / 64'd43;
      22: hgc_atan_term = p / 64'd45;
      23: hgc_atan_term = p / 64'd47;
      24: hgc_atan_term = p / 64'd49;
      25: hgc_atan_term = p / 64'd51;
      26: hgc_atan_term = p / 64'd53;
      27: hgc_atan_term = p / 64'd55;
      28: hgc_atan_term = p / 64'd57;
      29: hgc_atan_term = p / 64'd59;
      30: hgc_atan_term = p / 64'd61;
      default: hgc_atan_term = 64'd0;
    endcase
  endfunction

  // atan(2^-i) in q30, evaluated at elaboration
  function automatic logic signed [HGC_CW-1:0] hgc_atan(int i);
    logic [63:0] acc;
    int          e;
    acc = 64'd0;
    if (i == 0) begin
      return HGC_CW'(HGC_PI_Q60 >> 32);
    end
    for (int k = 0; k <= 30; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        if ((k & 1) != 0) begin
          acc = acc - hgc_atan_term(k, e);
        end else begin
          acc = acc + hgc_atan_term(k, e);
        end
      end
    end
    return HGC_CW'(acc >> 32);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hgc_cordic_cell.sv -----
// one cordic micro-rotation, registered; rotation or vectoring mode
// depends on hgc_pkg
`timescale 1ns / 1ps
`default_nettype none

module hgc_cordic_cell #(
  parameter int SHIFT     = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                clk,
  input  logic                en,
  input  hgc_pkg::hgc_cordic_t din,
  output hgc_pkg::hgc_cordic_t dout
);
  import hgc_pkg::*;

  localparam logic signed [HGC_CW-1:0] ANGLE = hgc_atan(SHIFT);

  logic signed [HGC_CW-1:0] xi, yi, zi, dx, dy;
  hgc_cordic_t nxt;

  always_comb begin
    xi = din.x;
    yi = din.y;
    zi = din.z;
    dx = yi >>> SHIFT;
    dy = xi >>> SHIFT;
    nxt = din;
    if (VECTORING) begin
      // drive y toward zero
      if (yi > 0) begin
        nxt.x = xi + dx;
        nxt.y = yi - dy;
        nxt.z = zi + ANGLE;
      end else begin
        nxt.x = xi - dx;
        nxt.y = yi + dy;
        nxt.z = zi - ANGLE;
      end
    end else begin
      // turn toward the residual angle
      if (zi >= 0) begin
        nxt.x = xi - dx;
        nxt.y = yi + dy;
        nxt.z = zi - ANGLE;
      end else begin
        nxt.x = xi + dx;
        nxt.y = yi - dy;
        nxt.z = zi + ANGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hgc_sqrt_cell.sv -----
// one digit step of a restoring floor square root, registered
// depends on hgc_pkg
`timescale 1ns / 1ps
`default_nettype none

module hgc_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  hgc_pkg::hgc_sqrt_t din,
  output hgc_pkg::hgc_sqrt_t dout
);
  import hgc_pkg::*;

  localparam logic [HGC_SW-1:0] BIT = HGC_SW'(1) << (2 * STEP);

  logic [HGC_SW-1:0] trial;
  hgc_sqrt_t nxt;

  always_comb begin
    trial = din.res + BIT;
    if (din.rem >= trial) begin
      nxt.rem = din.rem - trial;
      nxt.res = (din.res >> 1) + BIT;
    end else begin
      nxt.rem = din.rem;
      nxt.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/haversine_geofence_check_top.sv -----
// top level of the haversine geofence check: full pipeline with output skid buffer
// depends on hgc_pkg, hgc_cordic_cell, hgc_sqrt_cell
//
//   channel   signals                          direction  meaning
//   --------  -------------------------------  ---------  ---------------------------
//   in        in_valid / in_ready / in_data    sink       one position fix per transfer
//   out       out_valid / out_ready / out_data source     distance and inside flag
//   cfg       cfg_we / cfg_index / cfg_data    sink       centre lat, centre lon, radius
//
// one fix per cycle while the skid is empty; the pipeline depth to the output register is
// set by the two cordic chains (sin/cos, then atan2) and the 31-step square root
// synchronous reset clears the valid line, out_valid, skid_valid and the config registers
// a result waiting at out is held in the output register; a second one goes to the skid
// register and the whole pipeline holds until the skid drains (in_ready = skid empty)
`timescale 1ns / 1ps
`default_nettype none

module haversine_geofence_check_top #(
  parameter int CORDIC_STAGES = hgc_pkg::HGC_CORDIC_STAGES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hgc_pkg::hgc_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hgc_pkg::hgc_out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import hgc_pkg::*;

  localparam int DEPTH = 2 * CORDIC_STAGES + HGC_SQRT_STEPS + 8;
  localparam logic signed [31:0] D2R = {1'b0, HGC_DEG2RAD[30:0]};

  // configuration
  logic signed [30:0] clat;
  logic signed [31:0] clon;
  logic [24:0]        radius;

  // pipeline advance: stops only while the skid register is full
  logic en;
  logic skid_valid;
  hgc_out_t skid_data;
  logic [DEPTH-1:0] vld;

  // wrap a coordinate difference into [-180, 180) degrees
  function automatic logic signed [31:0] wrap_deg(input logic signed [32:0] d);
    logic signed [33:0] w;
    w = {d[32], d};
    if (w >= HGC_HALF_DEG) begin
      w = w - HGC_FULL_DEG;
    end else if (w < -HGC_HALF_DEG) begin
      w = w + HGC_FULL_DEG;
    end
    return w[31:0];
  endfunction

  // |lat| folded into [0, 90] degrees, msb set when the cosine must be negated
  function automatic logic [32:0] fold_lat(input logic signed [30:0] lat);
    logic [31:0] m;
    logic        neg;
    m = lat[30] ? (32'd0 - {lat[30], lat}) : {1'b0, lat};
    neg = 1'b0;
    if (m > HGC_QUARTER_DEG) begin
      m = HGC_HALF_DEG_U - m;
      neg = 1'b1;
    end
    return {neg, m};
  endfunction

  // stage 0: differences, wrap and fold
  logic signed [30:0] plat;
  logic signed [31:0] plon;
  logic signed [32:0] dlat_raw, dlon_raw;
  logic [32:0] fold_c, fold_p;
  logic signed [31:0] r0_dlat, r0_dlon;
  logic [31:0] r0_mc, r0_mp;
  logic r0_neg;

  always_comb begin
    plat = in_data.pos_lat;
    plon = in_data.pos_lon;
    dlat_raw = {{2{plat[30]}}, plat} - {{2{clat[30]}}, clat};
    dlon_raw = {plon[31], plon} - {clon[31], clon};
    fold_c = fold_lat(clat);
    fold_p = fold_lat(plat);
  end

  // stage 1: degrees to radians, half angles for the haversine terms
  logic signed [63:0] prod_lat, prod_lon;
  logic [63:0] prod_c, prod_p;
  logic signed [HGC_CW-1:0] r1_hlat, r1_hlon, r1_ac, r1_ap;
  logic r1_neg;

  always_comb begin
    prod_lat = r0_dlat * D2R;
    prod_lon = r0_dlon * D2R;
    prod_c = {32'd0, r0_mc} * {33'd0, D2R[30:0]};
    prod_p = {32'd0, r0_mp} * {33'd0, D2R[30:0]};
  end

  // rotation chains: sin of half differences, cos of both latitudes
  hgc_cordic_t rot_lat [CORDIC_STAGES+1];
  hgc_cordic_t rot_lon [CORDIC_STAGES+1];
  hgc_cordic_t rot_c   [CORDIC_STAGES+1];
  hgc_cordic_t rot_p   [CORDIC_STAGES+1];
  logic [CORDIC_STAGES-1:0] neg_line;

  assign rot_lat[0] = '{x: HGC_KINV, y: '0, z: r1_hlat};
  assign rot_lon[0] = '{x: HGC_KINV, y: '0, z: r1_hlon};
  assign rot_c[0]   = '{x: HGC_KINV, y: '0, z: r1_ac};
  assign rot_p[0]   = '{x: HGC_KINV, y: '0, z: r1_ap};

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    hgc_cordic_cell #(.SHIFT(k), .VECTORING(1'b0)) u_lat (
      .clk(clk), .en(en), .din(rot_lat[k]), .dout(rot_lat[k+1]));
    hgc_cordic_cell #(.SHIFT(k), .VECTORING(1'b0)) u_lon (
      .clk(clk), .en(en), .din(rot_lon[k]), .dout(rot_lon[k+1]));
    hgc_cordic_cell #(.SHIFT(k), .VECTORING(1'b0)) u_c (
      .clk(clk), .en(en), .din(rot_c[k]), .dout(rot_c[k+1]));
    hgc_cordic_cell #(.SHIFT(k), .VECTORING(1'b0)) u_p (
      .clk(clk), .en(en), .din(rot_p[k]), .dout(rot_p[k+1]));
  end

  // stage 2: squares of the sines, product of the cosines
  logic signed [HGC_CW-1:0] s1, s2, cl, cp, cl_s;
  logic signed [65:0] r2_s1sq, r2_s2sq, r2_ccp;

  always_comb begin
    s1 = rot_lat[CORDIC_STAGES].y;
    s2 = rot_lon[CORDIC_STAGES].y;
    cl = rot_c[CORDIC_STAGES].x;
    cp = rot_p[CORDIC_STAGES].x;
    cl_s = neg_line[CORDIC_STAGES-1] ? -cl : cl;
  end

  // stage 3: cos product times sin^2 of the longitude half difference, in two parts
  logic signed [HGC_CW-1:0] cc;
  logic signed [34:0] s2_hi;
  logic signed [30:0] s2_lo;
  logic signed [65:0] r3_s1sq, r3_phi, r3_plo;

  always_comb begin
    cc = HGC_CW'(r2_ccp >>> 30);
    s2_hi = {1'b0, r2_s2sq[63:30]};
    s2_lo = {1'b0, r2_s2sq[29:0]};
  end

  // stage 4: haversine sum, stage 5: clamp to [0, 1]
  logic signed [65:0] r4_a;
  logic [60:0] r5_ua, r5_om;

  // square roots of a and 1-a
  hgc_sqrt_t sq_a [HGC_SQRT_STEPS+1];
  hgc_sqrt_t sq_b [HGC_SQRT_STEPS+1];

  assign sq_a[0] = '{rem: HGC_SW'(r5_ua), res: '0};
  assign sq_b[0] = '{rem: HGC_SW'(r5_om), res: '0};

  for (genvar k = 0; k < HGC_SQRT_STEPS; k++) begin : g_sqrt
    hgc_sqrt_cell #(.STEP(HGC_SQRT_STEPS - 1 - k)) u_a (
      .clk(clk), .en(en), .din(sq_a[k]), .dout(sq_a[k+1]));
    hgc_sqrt_cell #(.STEP(HGC_SQRT_STEPS - 1 - k)) u_b (
      .clk(clk), .en(en), .din(sq_b[k]), .dout(sq_b[k+1]));
  end

  // atan2(sqrt(a), sqrt(1-a)) by vectoring
  hgc_cordic_t vec [CORDIC_STAGES+1];

  assign vec[0] = '{x: {3'd0, sq_b[HGC_SQRT_STEPS].res[30:0]},
                    y: {3'd0, sq_a[HGC_SQRT_STEPS].res[30:0]},
                    z: '0};

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    hgc_cordic_cell #(.SHIFT(k), .VECTORING(1'b1)) u_v (
      .clk(clk), .en(en), .din(vec[k]), .dout(vec[k+1]));
  end

  // stage 6: angle times twice the earth radius, stage 7: round, saturate, compare
  logic signed [HGC_CW-1:0] zf;
  logic [31:0] zc;
  logic [55:0] r6_prod;
  logic [25:0] dist_raw, dist_sat;
  hgc_out_t r7_res;

  always_comb begin
    zf = vec[CORDIC_STAGES].z;
    zc = (zf < 0) ? 32'd0 : zf[31:0];
    dist_raw = 26'((r6_prod + 56'd536870912) >> 30);
    dist_sat = (dist_raw > HGC_HALF_CIRC) ? HGC_HALF_CIRC : dist_raw;
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      r0_dlat <= wrap_deg(dlat_raw);
      r0_dlon <= wrap_deg(dlon_raw);
      r0_mc   <= fold_c[31:0];
      r0_mp   <= fold_p[31:0];
      r0_neg  <= fold_c[32] ^ fold_p[32];

      r1_hlat <= HGC_CW'(prod_lat >>> 31);
      r1_hlon <= HGC_CW'(prod_lon >>> 31);
      r1_ac   <= HGC_CW'(prod_c >> 30);
      r1_ap   <= HGC_CW'(prod_p >> 30);
      r1_neg  <= r0_neg;

      neg_line <= {neg_line[CORDIC_STAGES-2:0], r1_neg};

      r2_s1sq <= s1 * s1;
      r2_s2sq <= s2 * s2;
      r2_ccp  <= cl_s * cp;

      r3_s1sq <= r2_s1sq;
      r3_phi  <= cc * s2_hi;
      r3_plo  <= cc * s2_lo;

      r4_a <= r3_s1sq + r3_phi + (r3_plo >>> 30);

      if (r4_a < 0) begin
        r5_ua <= '0;
      end else if (r4_a > $signed({5'd0, HGC_ONE_Q60})) begin
        r5_ua <= HGC_ONE_Q60;
      end else begin
        r5_ua <= r4_a[60:0];
      end
      if (r4_a < 0) begin
        r5_om <= HGC_ONE_Q60;
      end else if (r4_a > $signed({5'd0, HGC_ONE_Q60})) begin
        r5_om <= '0;
      end else begin
        r5_om <= HGC_ONE_Q60 - r4_a[60:0];
      end

      r6_prod <= {24'd0, zc} * {32'd0, HGC_TWO_R};

      r7_res.inside_res <= (dist_sat <= {1'b0, radius});
      r7_res.distance_m <= dist_sat[24:0];
    end
  end

  assign en       = !skid_valid;
  assign in_ready = en;

  // control: config, valid line, output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      clat       <= '0;
      clon       <= '0;
      radius     <= '0;
      vld        <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          HGC_REG_CLAT:   clat   <= cfg_data[30:0];
          HGC_REG_CLON:   clon   <= cfg_data;
          HGC_REG_RADIUS: radius <= cfg_data[24:0];
          default: ;
        endcase
      end
      if (en) begin
        vld <= {vld[DEPTH-2:0], in_valid};
      end
      if (skid_valid) begin
        // skid drains into the output register on a transfer
        if (out_ready) begin
          skid_valid <= 1'b0;
        end
      end else if (!out_valid || out_ready) begin
        out_valid <= vld[DEPTH-1];
      end else if (vld[DEPTH-1]) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || out_ready) begin
      out_data <= r7_res;
    end else begin
      skid_data <= r7_res;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> skid_valid)
    else $error("skid result dropped without a transfer");

  a_dist_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_data.distance_m} <= HGC_HALF_CIRC))
    else $error("distance above half circumference");

  a_inside_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.inside_res == (out_data.distance_m <= radius)))
    else $error("inside flag disagrees with distance and radius");
`endif

endmodule

`default_nettype wire

// ----- verif/hgc_distance_checker.sv -----
// checker for the haversine geofence check: watches in/out/cfg, predicts distance and flag
// depends on hgc_pkg; instantiated beside the block by haversine_geofence_check_top_tb
`timescale 1ns / 1ps

module hgc_distance_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  hgc_pkg::hgc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  hgc_pkg::hgc_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output int                pending
);
  import hgc_pkg::*;

  localparam int      NSTG     = HGC_CORDIC_STAGES;
  localparam longint  HALF_D   = 64'sd1800000000;
  localparam longint  ONE_Q60L = 64'sh1000000000000000;
  localparam longint  KINV_L   = 64'sh26DD3B6A;
  localparam longint  DEG2RAD  = 64'h3243F6A8885A308D / 64'd1800000000;
  localparam longint  MAX_DIST = 20015087;

  longint    ctr_lat, ctr_lon;
  longint    fence_radius;
  longint    atan_tab [0:NSTG-1];
  hgc_out_t  fence_results [$];

  // arctan table built from the alternating series
  function automatic longint atan_entry(int i);
    longint acc;
    int     e;
    acc = 0;
    if (i == 0) return longint'(64'h3243F6A8885A308D >> 32);
    for (int k = 0; ; k++) begin
      e = i * (2 * k + 1);
      if (e > 62) break;
      if (k & 1) acc -= longint'((64'd1 << (62 - e)) / (2 * k + 1));
      else acc += longint'((64'd1 << (62 - e)) / (2 * k + 1));
    end
    return longint'(64'(acc) >> 32);
  endfunction

  function automatic void cordic_rot(longint ang, output longint c, output longint s);
    longint x, y, dx, dy;
    x = KINV_L;
    y = 0;
    for (int i = 0; i < NSTG; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= atan_tab[i];
      end else begin
        x += dx; y -= dy; ang += atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_atan2(longint x, longint y);
    longint ang, dx, dy;
    ang = 0;
    for (int i = 0; i < NSTG; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += atan_tab[i];
      end else begin
        x -= dx; y += dy; ang -= atan_tab[i];
      end
    end
    return ang;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // sine of half the wrapped coordinate difference
  function automatic longint sin_half(longint d);
    longint c, s;
    if (d >= HALF_D) d -= 2 * HALF_D;
    else if (d < -HALF_D) d += 2 * HALF_D;
    cordic_rot((d * DEG2RAD) >>> 31, c, s);
    return s;
  endfunction

  // latitudes past the pole fold back and flip sign
  function automatic longint cos_lat(longint lat);
    longint c, s, m;
    bit     flip;
    m = lat < 0 ? -lat : lat;
    flip = 0;
    if (m > HALF_D / 2) begin
      m = HALF_D - m;
      flip = 1;
    end
    cordic_rot((m * DEG2RAD) >>> 30, c, s);
    return flip ? -c : c;
  endfunction

  function automatic hgc_out_t fence_distance(hgc_in_t fix);
    longint   s1, s2, cc, sq, hav, ang, dist_m;
    hgc_out_t r;
    s1 = sin_half(longint'(fix.pos_lat) - ctr_lat);
    s2 = sin_half(longint'(fix.pos_lon) - ctr_lon);
    cc = (cos_lat(ctr_lat) * cos_lat(longint'(fix.pos_lat))) >>> 30;
    sq = s2 * s2;
    hav = s1 * s1 + cc * (sq >> 30) + ((cc * longint'(sq & 64'h3FFFFFFF)) >>> 30);
    if (hav < 0) hav = 0;
    if (hav > ONE_Q60L) hav = ONE_Q60L;
    ang = cordic_atan2(floor_sqrt(ONE_Q60L - hav), floor_sqrt(hav));
    if (ang < 0) ang = 0;
    dist_m = (ang * 2 * 6371000 + (64'sd1 << 29)) >> 30;
    if (dist_m > MAX_DIST) dist_m = MAX_DIST;
    r.inside_res = dist_m <= fence_radius;
    r.distance_m = dist_m[24:0];
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NSTG; i++) atan_tab[i] = atan_entry(i);
  end

  assign pending = fence_results.size();

  always @(posedge clk) begin
    hgc_out_t want;
    if (rst) begin
      ctr_lat <= 0;
      ctr_lon <= 0;
      fence_radius <= 0;
      fail_count <= 0;
      fence_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          HGC_REG_CLAT:   ctr_lat <= longint'($signed(cfg_data[30:0]));
          HGC_REG_CLON:   ctr_lon <= longint'($signed(cfg_data));
          HGC_REG_RADIUS: fence_radius <= longint'(cfg_data[24:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) fence_results.push_back(fence_distance(in_data));
      if (out_valid && out_ready) begin
        if (fence_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = fence_results.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: expected inside %0d dist %0d, got inside %0d dist %0d",
                       want.inside_res, want.distance_m,
                       out_data.inside_res, out_data.distance_m);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- verif/haversine_geofence_check_top_tb.sv -----
// testbench top for the haversine geofence check: clock, reset, stimulus, verdict
// depends on hgc_pkg, haversine_geofence_check_top and hgc_distance_checker
`timescale 1ns / 1ps

module haversine_geofence_check_top_tb;
  import hgc_pkg::*;

  localparam int LAT_MAX    = 900000000;
  localparam int LON_MAX    = 1800000000;
  localparam int RAD_MAX    = 20015087;
  localparam int DRAIN      = 2 * HGC_CORDIC_STAGES + 60;
  localparam int IDLE_LIMIT = 20000;

  logic     clk = 0;
  logic     rst = 1;
  logic     in_valid = 0;
  logic     in_ready;
  hgc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 0;
  hgc_out_t out_data;
  logic     cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int  fail_count, pending;
  int  quiet_cycles = 0;
  bit  calm_tail = 0;     // no idling in the last part of the run
  bit  hold_sink = 0;     // long receiver hold-off request
  bit  all_sent = 0;

  always #6 clk = ~clk;

  haversine_geofence_check_top i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  hgc_distance_checker i_chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off to fill the pipeline
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  function automatic int rand_lat();
    case ($urandom_range(0, 5))
      0: return LAT_MAX;
      1: return -LAT_MAX;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
    endcase
  endfunction

  function automatic int rand_lon();
    case ($urandom_range(0, 5))
      0: return LON_MAX;
      1: return -LON_MAX;
      2: return $signed($urandom()) ; // full 32-bit pattern, also beyond range
      default: return $signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
    endcase
  endfunction

  task automatic send_fix(int lat, int lon, bit gaps);
    int n;
    if (gaps && !calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 15);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_data.pos_lat <= lat[30:0];
    in_data.pos_lon <= lon;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_and_drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // one write cycle, then the enable goes low again before the task returns
  task automatic write_reg(hgc_reg_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic set_fence(int lat, int lon, int rad);
    idle_and_drain();
    write_reg(HGC_REG_CLAT, lat);
    write_reg(HGC_REG_CLON, lon);
    write_reg(HGC_REG_RADIUS, rad);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset fence, poles, antimeridian wrap, over-range latitude, same point
    send_fix(0, 0, 0);
    send_fix(LAT_MAX, 0, 0);
    send_fix(-LAT_MAX, 0, 0);
    send_fix(0, LON_MAX, 0);
    send_fix(0, -LON_MAX, 0);
    send_fix(1073741823, 0, 0);        // latitude past the pole, max positive code
    send_fix(-1073741824, -1, 0);
    send_fix(0, 32'h7FFFFFFF, 0);
    send_fix(0, 32'h80000000, 0);
    set_fence(LAT_MAX, LON_MAX, RAD_MAX);
    send_fix(-LAT_MAX, -LON_MAX, 0);
    send_fix(LAT_MAX, LON_MAX, 0);
    send_fix(0, 0, 0);
    set_fence(-LAT_MAX, -LON_MAX, 32'h1FFFFFF);   // radius beyond range always inside
    send_fix(LAT_MAX, 0, 0);
    send_fix(0, 1, 0);
    set_fence(100, 1799999999, 1000);
    send_fix(100, -1800000000, 0);     // wrap across the antimeridian, tiny distance
    send_fix(0, -1799999000, 0);
    send_fix(-100, 1799999999, 0);
    // ignored index must not disturb the registers
    idle_and_drain();
    write_reg(hgc_reg_t'(2'd3), 32'hFFFFFFFF);
    send_fix(100, 1799999999, 0);

    // random phases with a new fence each, including the receiver hold-off
    for (int ph = 0; ph < 12; ph++) begin
      int clat, clon, rad;
      clat = rand_lat();
      clon = rand_lon();
      rad = ph % 4 == 0 ? 0 : ph % 4 == 1 ? RAD_MAX : $urandom_range(0, RAD_MAX);
      set_fence(clat, clon, rad);
      if (ph == 5) hold_sink = 1;
      if (ph == 10) calm_tail = 1;
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 2) == 0)
          // near the centre so the inside flag flips often
          send_fix(clat + $signed($urandom_range(0, 4000000)) - 2000000,
                   clon + $signed($urandom_range(0, 4000000)) - 2000000, 1);
        else
          send_fix(rand_lat(), rand_lon(), 1);
      end
    end
    in_valid <= 0;
    all_sent = 1;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
